/* rtl/byte_substring_search_assert.svh */
// Assertion macros for the byte substring search block.
`ifndef BYTE_SUBSTRING_SEARCH_ASSERT_SVH
`define BYTE_SUBSTRING_SEARCH_ASSERT_SVH

// Checked on every clock edge outside reset.
`define BSS_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define BSS_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/bss_pkg.sv */
// Shared types, constants and helpers of the byte substring search block.
`default_nettype none
package bss_pkg;

  localparam int unsigned PATTERN_BITS   = 64;
  localparam int unsigned LENGTH_BITS    = 4;
  localparam int unsigned OFFSET_BITS    = 16;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 64;

  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_LF = 8'd10;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CASE_FOLD      = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_MODE      = 2'd3;

  typedef struct packed {
    logic shift;
    logic fold;
  } bss_cell_ctrl_t;

  // Upper-case fold of ASCII a-z when enabled.
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= 8'd97 && c <= 8'd122) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  function automatic logic bytes_differ(input logic [7:0] a, input logic [7:0] b,
                                        input logic en);
    return fold_byte(a, en) != fold_byte(b, en);
  endfunction

endpackage
`default_nettype wire

/* rtl/bss_if.sv */
// Input and result channels of the byte substring search block.
`default_nettype none
interface bss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface bss_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] match_offset;
  logic        position_overflow;

  modport source (output valid, output found, output match_offset,
                  output position_overflow, input ready);
  modport sink (input valid, input found, input match_offset,
                input position_overflow, output ready);
endinterface
`default_nettype wire

/* rtl/byte_substring_search.sv */
// A result is registered at the edge that accepts its byte.
// Throughput: one byte per cycle while the output is not stalled; the window of
// PATTERN_MAX-1 cells shifts once per accepted non-last byte and all cells compare in the same cycle.
// A byte is taken while the output register is empty or being drained.
// Reset (synchronous, rst_n low) clears configuration and search state; no clearing pass.
`default_nettype none
module byte_substring_search
  import bss_pkg::*;
#(
  parameter int unsigned PATTERN_MAX   = 8,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  bss_in_if.sink                         in_bus,
  bss_out_if.source                      out_bus,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned SW = (PB + 1 > OFFSET_BITS + 1) ? PB + 1 : OFFSET_BITS + 1;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

  // configuration
  logic [PATTERN_BITS-1:0] pattern_r;
  logic [LENGTH_BITS-1:0]  length_r;
  logic                    fold_r;
  logic                    line_mode_r;

  // search state
  logic [PB-1:0] pos_r,      pos_nxt;
  logic          done_r,     done_nxt;
  logic          sat_r,      sat_nxt;
  logic          line_seen_r, line_seen_nxt;
  logic [PB-1:0] line_pos_r, line_pos_nxt;

  // result register
  logic                   out_valid_r;
  logic                   found_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic                   ovf_r;

  logic                   accept;
  logic                   last;
  logic [7:0]             cur;
  logic [LENGTH_BITS-1:0] len_c;
  logic                   enough;
  logic [SW-1:0]          start_w;
  logic                   line_now;
  logic                   seen_eff;
  logic [PB-1:0]          lpos_eff;
  logic                   line_block;
  logic                   hit;
  logic                   produce;
  logic [OFFSET_BITS-1:0] offset_c;
  bss_cell_ctrl_t         cell_ctrl;

  logic [7:0] chain [PATTERN_MAX];
  logic [7:0] pat_sel [PATTERN_MAX];
  logic       active [PATTERN_MAX];
  logic       miss [PATTERN_MAX];
  logic       any_miss;

  assign accept = in_bus.valid && in_bus.ready;
  assign last   = in_bus.last_byte;
  assign cur    = in_bus.byte_value;
  assign in_bus.ready = !out_valid_r || out_bus.ready;

  assign len_c = (length_r > LENGTH_BITS'(PATTERN_MAX)) ? LENGTH_BITS'(PATTERN_MAX) : length_r;

  // window position w holds pattern byte len-1-w
  for (genvar w = 0; w < PATTERN_MAX; w++) begin : g_sel
    logic [2:0] idx;
    assign idx        = 3'(len_c - LENGTH_BITS'(w) - LENGTH_BITS'(1));
    assign pat_sel[w] = pattern_r[{idx, 3'b000} +: 8];
    assign active[w]  = len_c > LENGTH_BITS'(w);
  end

  assign cell_ctrl.shift = accept && !last;
  assign cell_ctrl.fold  = fold_r;

  assign chain[0] = cur;
  assign miss[0]  = active[0] && bytes_differ(cur, pat_sel[0], fold_r);

  for (genvar k = 0; k + 1 < PATTERN_MAX; k++) begin : g_cell
    bss_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .byte_in  (chain[k]),
      .pat_byte (pat_sel[k+1]),
      .active   (active[k+1]),
      .byte_out (chain[k+1]),
      .miss     (miss[k+1])
    );
  end

  always_comb begin
    any_miss = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      any_miss = any_miss | miss[i];
    end
  end

  assign enough  = (SW'(pos_r) + SW'(1)) >= SW'(len_c);
  assign start_w = SW'(pos_r) + SW'(1) - SW'(len_c);

  // first CR or LF of the buffer, including the current byte
  assign line_now   = line_mode_r && !line_seen_r && (cur == BYTE_CR || cur == BYTE_LF);
  assign seen_eff   = line_seen_r || line_now;
  assign lpos_eff   = line_seen_r ? line_pos_r : pos_r;
  assign line_block = line_mode_r && seen_eff && (start_w >= SW'(lpos_eff));

  assign hit     = (len_c == '0) || (enough && !any_miss && !line_block);
  assign produce = accept && !done_r && (hit || last);
  // empty pattern always reports offset 0
  assign offset_c = (len_c == '0) ? '0 :
                    (start_w > SW'({OFFSET_BITS{1'b1}})) ? {OFFSET_BITS{1'b1}}
                                                         : start_w[OFFSET_BITS-1:0];

  always_comb begin
    pos_nxt       = pos_r;
    done_nxt      = done_r;
    sat_nxt       = sat_r;
    line_seen_nxt = line_seen_r;
    line_pos_nxt  = line_pos_r;
    if (accept) begin
      if (last) begin
        pos_nxt       = '0;
        done_nxt      = 1'b0;
        sat_nxt       = 1'b0;
        line_seen_nxt = 1'b0;
        line_pos_nxt  = '0;
      end else begin
        done_nxt      = done_r || produce;
        line_seen_nxt = seen_eff;
        line_pos_nxt  = lpos_eff;
        if (pos_r == POS_MAX) begin
          sat_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + PB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= '0;
      length_r    <= '0;
      fold_r      <= 1'b0;
      line_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_BYTES:  pattern_r   <= cfg_data[PATTERN_BITS-1:0];
        REG_PATTERN_LENGTH: length_r    <= cfg_data[LENGTH_BITS-1:0];
        REG_CASE_FOLD:      fold_r      <= cfg_data[0];
        REG_LINE_MODE:      line_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      done_r      <= 1'b0;
      sat_r       <= 1'b0;
      line_seen_r <= 1'b0;
      line_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      sat_r       <= sat_nxt;
      line_seen_r <= line_seen_nxt;
      line_pos_r  <= line_pos_nxt;
      if (produce) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      found_r  <= hit;
      offset_r <= hit ? offset_c : '0;
      ovf_r    <= sat_r;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.found             = found_r;
  assign out_bus.match_offset      = offset_r;
  assign out_bus.position_overflow = ovf_r;

`include "byte_substring_search_assert.svh"

  `BSS_CHECK(a_last_clears, (accept && last) |=> (!done_r && pos_r == '0 && !sat_r), "last byte did not clear the search state")
  `BSS_CHECK(a_new_result_source, $rose(out_valid_r) |-> $past(accept && !done_r), "result raised without a fresh request")
  `BSS_CHECK(a_sat_pinned, sat_r |-> (pos_r == POS_MAX), "saturated flag without pinned position")
  `BSS_CHECK_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r, "result valid straight after reset")

endmodule
`default_nettype wire

/* rtl/bss_cell.sv */
// One window cell: holds an earlier byte and compares it with its pattern byte.
`default_nettype none
module bss_cell
  import bss_pkg::*;
(
  input  wire logic           clk,
  input  wire bss_cell_ctrl_t ctrl,
  input  wire logic [7:0]     byte_in,
  input  wire logic [7:0]     pat_byte,
  input  wire logic           active,
  output logic [7:0]          byte_out,
  output logic                miss
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign miss     = active && bytes_differ(byte_r, pat_byte, ctrl.fold);

endmodule
`default_nettype wire
